// File: sv/gdd_pkg.sv
package gdd_pkg;

    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int COUNT_W = 23;
    localparam int OPA_W   = 15;
    localparam int OPB_W   = 13;

    // floor(x * RECIP_100 / 2^19) == floor(x / 100) for x below 43699
    localparam logic [OPB_W-1:0] RECIP_100 = 13'd5243;
    localparam logic [OPB_W-1:0] DAYS_YEAR = 13'd365;
    localparam logic [OPB_W-1:0] ONE       = 13'd1;

    // shift applied to the product before accumulation
    localparam logic [1:0] SH_0  = 2'd0;
    localparam logic [1:0] SH_2  = 2'd1;
    localparam logic [1:0] SH_19 = 2'd2;

    // steps per date
    localparam logic [2:0] K_YEAR = 3'd0;
    localparam logic [2:0] K_Q4   = 3'd1;
    localparam logic [2:0] K_Q100 = 3'd2;
    localparam logic [2:0] K_Q400 = 3'd3;
    localparam logic [2:0] K_MDAY = 3'd4;

    typedef struct packed {
        logic [YEAR_W-1:0]  start_year;
        logic [MONTH_W-1:0] start_month;
        logic [DAY_W-1:0]   start_day;
        logic [YEAR_W-1:0]  end_year;
        logic [MONTH_W-1:0] end_month;
        logic [DAY_W-1:0]   end_day;
    } t_req;

    typedef struct packed {
        logic signed [COUNT_W-1:0] day_count;
        logic                      invalid;
    } t_rsp;

    typedef struct packed {
        logic       clr;
        logic       en;
        logic       start_date;
        logic [2:0] k;
    } t_step;

    typedef struct packed {
        logic             clr;
        logic             en;
        logic             sub;
        logic [1:0]       sh;
        logic [OPA_W-1:0] a;
        logic [OPB_W-1:0] b;
    } t_mac_op;

    function automatic logic date_ok(input logic [MONTH_W-1:0] m, input logic [DAY_W-1:0] d);
        date_ok = (m >= 4'd1) && (m <= 4'd12) && (d >= 5'd1);
    endfunction

    // days before the first of month m in a common year
    function automatic logic [8:0] month_base(input logic [MONTH_W-1:0] m);
        case (m)
            4'd2:    month_base = 9'd31;
            4'd3:    month_base = 9'd59;
            4'd4:    month_base = 9'd90;
            4'd5:    month_base = 9'd120;
            4'd6:    month_base = 9'd151;
            4'd7:    month_base = 9'd181;
            4'd8:    month_base = 9'd212;
            4'd9:    month_base = 9'd243;
            4'd10:   month_base = 9'd273;
            4'd11:   month_base = 9'd304;
            4'd12:   month_base = 9'd334;
            default: month_base = 9'd0;
        endcase
    endfunction

endpackage

// File: sv/gregorian_day_difference.sv
// Signed day count between two proleptic Gregorian dates.
//
// Request channel i_valid/i_ready carries both dates in i_data; the response
// channel o_valid/o_ready returns day_count (end minus start) and invalid.
// A month outside 1..12 or a day outside 1..31 in either date gives invalid
// with a zero count. Years above MAX_YEAR are clamped to MAX_YEAR.
//
// Each date is reduced to a day number by one shared multiply-accumulate
// unit in five steps: 365 per year, the leap counts y/4 (by shift), y/100
// and y/400 (by reciprocal multiply), then month base plus day. The end
// date is added first and the start date subtracted. An invalid request
// shows its response in the cycle after it is accepted. One request is in
// flight at a time: i_ready is high only when the block is idle, so a new
// request is taken only once the last response has been taken. When the
// receiver stalls, the response is held on o_data with o_valid high and no
// new request is taken. Reset drops any request in flight and returns the
// control to idle; the request and accumulator registers are not reset.
module gregorian_day_difference import gdd_pkg::*; #(
    parameter int MAX_YEAR = 9999
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic i_ready,
    input  t_req i_data,
    input  logic o_ready,
    output logic o_valid,
    output t_rsp o_data
);

    localparam logic [16:0] MaxYear = 17'(MAX_YEAR);

    t_req    r_req;
    logic    r_invalid;
    logic    start;
    logic    bad;
    logic    done;
    t_step   step;
    t_mac_op op;
    logic signed [COUNT_W-1:0] acc;

    logic [YEAR_W-1:0]  y;
    logic [MONTH_W-1:0] m;
    logic [DAY_W-1:0]   d;
    logic [YEAR_W-1:0]  y_sat;
    logic [OPA_W-1:0]   y_adj;
    logic [OPA_W-1:0]   y_400;

    assign start = i_valid && i_ready;
    assign bad   = !date_ok(i_data.start_month, i_data.start_day)
                || !date_ok(i_data.end_month, i_data.end_day);

    always_ff @(posedge i_clk) begin
        if (start) begin
            r_req     <= i_data;
            r_invalid <= bad;
        end
    end

    gdd_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_bad   (bad),
        .i_take  (o_valid && o_ready),
        .o_idle  (i_ready),
        .o_done  (done),
        .o_step  (step)
    );

    assign y = step.start_date ? r_req.start_year  : r_req.end_year;
    assign m = step.start_date ? r_req.start_month : r_req.end_month;
    assign d = step.start_date ? r_req.start_day   : r_req.end_day;

    // past February the leap day of this year counts: use the leaps before y+1
    assign y_sat = ({3'b0, y} > MaxYear) ? MaxYear[YEAR_W-1:0] : y;
    assign y_adj = {1'b0, y_sat} + OPA_W'(m > 4'd2);
    assign y_400 = OPA_W'((y_adj + OPA_W'(399)) >> 2);

    always_comb begin
        op.clr = step.clr;
        op.en  = step.en;
        op.sub = step.start_date;
        op.sh  = SH_0;
        op.a   = {1'b0, y_sat};
        op.b   = DAYS_YEAR;
        unique case (step.k)
            K_YEAR: begin
                op.a = {1'b0, y_sat};
                op.b = DAYS_YEAR;
            end
            K_Q4: begin
                op.a  = y_adj + OPA_W'(3);
                op.b  = ONE;
                op.sh = SH_2;
            end
            K_Q100: begin
                op.a   = y_adj + OPA_W'(99);
                op.b   = RECIP_100;
                op.sh  = SH_19;
                op.sub = !step.start_date;
            end
            K_Q400: begin
                op.a  = y_400;
                op.b  = RECIP_100;
                op.sh = SH_19;
            end
            K_MDAY: begin
                op.a = OPA_W'(month_base(m)) + OPA_W'(d) - OPA_W'(1);
                op.b = ONE;
            end
            default: op.en = 1'b0;
        endcase
    end

    gdd_mac u_mac (
        .i_clk (i_clk),
        .i_op  (op),
        .o_acc (acc)
    );

    assign o_valid          = done;
    assign o_data.day_count = r_invalid ? '0 : acc;
    assign o_data.invalid   = r_invalid;

endmodule

// File: sv/gdd_mac.sv
module gdd_mac import gdd_pkg::*; (
    input  logic                      i_clk,
    input  t_mac_op                   i_op,
    output logic signed [COUNT_W-1:0] o_acc
);

    logic [OPA_W+OPB_W-1:0] prod;
    logic [COUNT_W-1:0]     term;
    logic [COUNT_W-1:0]     r_acc;
    logic [COUNT_W-1:0]     n_acc;

    assign prod = i_op.a * i_op.b;

    always_comb begin
        case (i_op.sh)
            SH_2:    term = COUNT_W'(prod >> 2);
            SH_19:   term = COUNT_W'(prod >> 19);
            default: term = COUNT_W'(prod);
        endcase
    end

    // accumulate modulo 2^COUNT_W; the final difference wraps the same way
    always_comb begin
        n_acc = r_acc;
        if (i_op.clr) begin
            n_acc = '0;
        end else if (i_op.en) begin
            n_acc = i_op.sub ? r_acc - term : r_acc + term;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
    end

    assign o_acc = r_acc;

endmodule

// File: sv/gdd_ctrl.sv
module gdd_ctrl import gdd_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  logic  i_bad,
    input  logic  i_take,
    output logic  o_idle,
    output logic  o_done,
    output t_step o_step
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_OUT  = 2'd2;

    logic [1:0] r_state, n_state;
    logic [2:0] r_k, n_k;
    logic       r_date, n_date;

    always_comb begin
        n_state = r_state;
        n_k     = r_k;
        n_date  = r_date;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = i_bad ? S_OUT : S_RUN;
                    n_k     = K_YEAR;
                    n_date  = 1'b0;
                end
            end
            S_RUN: begin
                if (r_k == K_MDAY) begin
                    n_k = K_YEAR;
                    if (r_date) begin
                        n_state = S_OUT;
                    end else begin
                        n_date = 1'b1;
                    end
                end else begin
                    n_k = r_k + 3'd1;
                end
            end
            S_OUT: begin
                if (i_take) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_k     <= K_YEAR;
            r_date  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
            r_date  <= n_date;
        end
    end

    assign o_idle            = (r_state == S_IDLE);
    assign o_done            = (r_state == S_OUT);
    assign o_step.clr        = i_start;
    assign o_step.en         = (r_state == S_RUN);
    assign o_step.start_date = r_date;
    assign o_step.k          = r_k;

endmodule

// File: sv/gdd_checker.sv
module gdd_checker import gdd_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_valid,
    input logic i_ready,
    input t_req i_data,
    input logic o_ready,
    input logic o_valid,
    input t_rsp o_data
);

    logic bad_req;

    assign bad_req = i_data.start_month == 4'd0 || i_data.start_month > 4'd12
                  || i_data.end_month == 4'd0 || i_data.end_month > 4'd12
                  || i_data.start_day == 5'd0 || i_data.end_day == 5'd0;

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !i_ready)
        else $error("request taken while a response is pending");

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_ready) |=> (o_valid && $stable(o_data)))
        else $error("stalled response changed");

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.invalid) |-> (o_data.day_count == '0))
        else $error("invalid response with nonzero count");

    a_bad_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && i_ready && bad_req) |=> (o_valid && o_data.invalid))
        else $error("bad date not flagged on the next cycle");

endmodule

bind gregorian_day_difference gdd_checker u_gdd_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .i_ready (i_ready),
    .i_data  (i_data),
    .o_ready (o_ready),
    .o_valid (o_valid),
    .o_data  (o_data)
);

// File: verif/testbench.sv
module testbench import gdd_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int YEAR_CAP    = 9999;
    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_REQS = 900;
    localparam int SETTLE      = 16;

    // days per month in a common year
    localparam int MONTH_DAYS [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

    class date_diff_checker;
        t_rsp awaited[$];
        int   failures;

        function new();
            failures = 0;
        endfunction

        static function bit leap_year(int unsigned y);
            return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
        endfunction

        // days from 0000-01-01 to the given date, year clamped to the cap
        static function int unsigned day_ordinal(int unsigned y, int unsigned m,
                                                 int unsigned d);
            int unsigned n;
            if (y > YEAR_CAP) y = YEAR_CAP;
            n = y * 365 + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
            for (int i = 0; i + 1 < m && i < 12; i++) begin
                n += MONTH_DAYS[i];
                if (i == 1 && leap_year(y)) n += 1;
            end
            return n + d - 1;
        endfunction

        static function bit date_valid(int unsigned m, int unsigned d);
            return m >= 1 && m <= 12 && d >= 1 && d <= 31;
        endfunction

        function void note_request(t_req r);
            t_rsp rsp;
            int   diff;
            if (!date_valid(r.start_month, r.start_day) ||
                !date_valid(r.end_month, r.end_day)) begin
                rsp.day_count = '0;
                rsp.invalid   = 1'b1;
            end else begin
                diff = int'(day_ordinal(r.end_year, r.end_month, r.end_day)) -
                       int'(day_ordinal(r.start_year, r.start_month, r.start_day));
                rsp.day_count = diff[COUNT_W-1:0];
                rsp.invalid   = 1'b0;
            end
            awaited.push_back(rsp);
        endfunction

        function void check_response(t_rsp got);
            t_rsp want;
            if (awaited.size() == 0) begin
                $error("response with no request pending: day_count %0d invalid %0b",
                       got.day_count, got.invalid);
                failures++;
                return;
            end
            want = awaited.pop_front();
            if (got.day_count !== want.day_count) begin
                $error("day_count: expected %0d, got %0d", want.day_count, got.day_count);
                failures++;
            end
            if (got.invalid !== want.invalid) begin
                $error("invalid: expected %0b, got %0b", want.invalid, got.invalid);
                failures++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_valid;
    logic i_ready;
    t_req i_data;
    logic o_ready;
    logic o_valid;
    t_rsp o_data;

    date_diff_checker board = new();
    bit steady;
    int cycles = 0;

    gregorian_day_difference #(
        .MAX_YEAR(YEAR_CAP)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_ready (i_ready),
        .i_data  (i_data),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .o_data  (o_data)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    function automatic t_req make_req(int sy, int sm, int sd, int ey, int em, int ed);
        t_req r;
        r.start_year  = YEAR_W'(sy);
        r.start_month = MONTH_W'(sm);
        r.start_day   = DAY_W'(sd);
        r.end_year    = YEAR_W'(ey);
        r.end_month   = MONTH_W'(em);
        r.end_day     = DAY_W'(ed);
        return r;
    endfunction

    function automatic int pick_year();
        if ($urandom_range(0, 7) == 0) return $urandom_range(0, 16383);
        return $urandom_range(0, YEAR_CAP);
    endfunction

    function automatic t_req random_request();
        t_req r;
        int   sy;
        int   ey;
        sy = pick_year();
        ey = pick_year();
        // keep some pairs close so month and day ordering matters
        if ($urandom_range(0, 3) == 0) begin
            ey = sy + $urandom_range(0, 4) - 2;
            if (ey < 0) ey = 0;
            if (ey > 16383) ey = 16383;
        end
        r = make_req(sy, $urandom_range(1, 12), $urandom_range(1, 31),
                     ey, $urandom_range(1, 12), $urandom_range(1, 31));
        if ($urandom_range(0, 9) == 0) begin
            r.start_month = MONTH_W'($urandom_range(0, 15));
            r.start_day   = DAY_W'($urandom_range(0, 31));
        end
        if ($urandom_range(0, 9) == 0) begin
            r.end_month = MONTH_W'($urandom_range(0, 15));
            r.end_day   = DAY_W'($urandom_range(0, 31));
        end
        return r;
    endfunction

    task automatic send_request(t_req r);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= r;
        do @(posedge i_clk); while (!i_ready);
        board.note_request(r);
    endtask

    // hold off new requests until every response is back
    task automatic drain();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (board.awaited.size() != 0);
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_data  = '0;
        o_ready = 1'b0;
        steady  = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // same date, full span both ways, clamped years
        send_request(make_req(2000, 1, 1, 2000, 1, 1));
        send_request(make_req(0, 1, 1, 9999, 12, 31));
        send_request(make_req(9999, 12, 31, 0, 1, 1));
        send_request(make_req(16383, 15 - 3, 31, 9999, 12, 31));
        send_request(make_req(10000, 6, 15, 16383, 6, 15));
        send_request(make_req(0, 1, 1, 16383, 12, 31));
        // leap rules around February
        send_request(make_req(2000, 2, 28, 2000, 3, 1));
        send_request(make_req(1900, 2, 28, 1900, 3, 1));
        send_request(make_req(2004, 2, 28, 2004, 3, 1));
        send_request(make_req(0, 2, 29, 1, 1, 1));
        send_request(make_req(2100, 3, 1, 2000, 3, 1));
        // day past the end of its month
        send_request(make_req(2021, 4, 31, 2021, 5, 1));
        send_request(make_req(2021, 2, 30, 2021, 3, 2));
        // bad month or day on either side, then a valid year boundary
        send_request(make_req(2020, 0, 1, 2020, 1, 1));
        send_request(make_req(2020, 13, 1, 2020, 1, 1));
        send_request(make_req(2020, 15, 31, 2020, 1, 1));
        send_request(make_req(2020, 1, 0, 2020, 1, 1));
        send_request(make_req(2020, 1, 1, 2020, 0, 1));
        send_request(make_req(2020, 1, 1, 2020, 13, 5));
        send_request(make_req(2020, 1, 1, 2020, 12, 0));
        send_request(make_req(16383, 15, 31, 16383, 15, 31));
        send_request(make_req(0, 0, 0, 0, 0, 0));
        send_request(make_req(1, 12, 31, 2, 1, 1));
        drain();

        for (int n = 0; n < RANDOM_REQS; n++) begin
            if (n % 100 == 0) steady = ($urandom_range(0, 3) == 0);
            if (n == 300 || n == 600) drain();
            send_request(random_request());
        end

        drain();
        repeat (SETTLE) @(posedge i_clk);
        if (board.awaited.size() != 0) begin
            $error("%0d responses never arrived", board.awaited.size());
            board.failures++;
        end
        if (board.failures == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

    // response side: take each response after a random stall, or at once while steady
    initial begin
        int gap;
        @(posedge i_rst_n);
        forever begin
            gap = steady ? 0 : $urandom_range(0, 10);
            if (gap > 0) begin
                o_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            o_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
            board.check_response(o_data);
        end
    end

endmodule
